// ----- hw/rtl/tpra_pkg.sv -----
// Shared types and constants for the two-point rigid alignment map unit.
// No dependencies.
`default_nettype none

package tpra_pkg;

    localparam int COORD_W  = 32;   // coordinate width, Q16.16
    localparam int NUM_REGS = 8;    // calibration registers
    localparam int ADDR_W   = 5;    // byte address, 4 bytes per register
    localparam int ROT_FRAC = 30;   // rotation terms are Q2.30
    localparam int VEC_W    = COORD_W + 1;       // difference vectors
    localparam int PROD_W   = 2 * VEC_W;         // shared multiplier result
    localparam int ACC_W    = PROD_W + 1;        // sum of two products
    localparam int RND_W    = ACC_W - ROT_FRAC;  // rounded sum
    localparam int SHIFT_W  = 48;                // offset width

    // register indexes
    localparam logic [2:0] REG_SRC_A_X = 3'd0;
    localparam logic [2:0] REG_SRC_A_Y = 3'd1;
    localparam logic [2:0] REG_SRC_B_X = 3'd2;
    localparam logic [2:0] REG_SRC_B_Y = 3'd3;
    localparam logic [2:0] REG_DST_A_X = 3'd4;
    localparam logic [2:0] REG_DST_A_Y = 3'd5;
    localparam logic [2:0] REG_DST_B_X = 3'd6;
    localparam logic [2:0] REG_DST_B_Y = 3'd7;

    // result status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_DEGN = 2'd1;
    localparam logic [1:0] STAT_SAT  = 2'd2;

    // sequencer states
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_NORM = 7'b0000010,
        S_MAC  = 7'b0000100,
        S_POST = 7'b0001000,
        S_SQRT = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    // multiply-accumulate jobs
    typedef enum logic [2:0] {
        J_SQ   = 3'd0,
        J_COS  = 3'd1,
        J_SIN  = 3'd2,
        J_SHX  = 3'd3,
        J_SHY  = 3'd4,
        J_MAPX = 3'd5,
        J_MAPY = 3'd6
    } job_t;

    // clamp a rounded rotation term to [-1.0, +1.0] in Q2.30
    function automatic logic signed [COORD_W-1:0] clamp_unit(
        input logic signed [RND_W-1:0] v
    );
        logic signed [RND_W-1:0] one;
        one = RND_W'(1) <<< ROT_FRAC;
        if (v > one)
            return COORD_W'(one);
        else if (v < -one)
            return COORD_W'(-one);
        else
            return v[COORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/two_point_rigid_align_map_unit.sv -----
// Two-point rigid alignment map: calibration registers, derivation sequencer
// and point mapping on one shared multiplier. Depends on tpra_pkg.
`default_nettype none

// Channel  | Signals                                        | Direction
// ---------+------------------------------------------------+----------
// point    | in_valid, in_ready, point_x, point_y           | in
// result   | out_valid, out_ready, mapped_x/_y, status      | out
// config   | psel, penable, pwrite, paddr, pwdata, prdata   | in/out
//
// A point with the transform already derived makes two multiply-accumulate
// passes, for x and then for y, before its result is held.
// The first point after reset or a register write also derives the transform:
// per vector normalise steps, a squaring pass, 31 square-root steps and two
// divisions, then four passes for cos, sin and the two offsets.
// The shared multiplier and the bit-serial root and divide do this work.
// Reset clears the registers and the transform. One item is in work at a time;
// in_ready is low from acceptance until the result is taken.

module two_point_rigid_align_map_unit (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire [tpra_pkg::ADDR_W-1:0]         paddr,
    input  wire [31:0]                         pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire signed [tpra_pkg::COORD_W-1:0] point_x,
    input  wire signed [tpra_pkg::COORD_W-1:0] point_y,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic signed [tpra_pkg::COORD_W-1:0] mapped_x,
    output logic signed [tpra_pkg::COORD_W-1:0] mapped_y,
    output logic [1:0]                         status
);
    import tpra_pkg::*;

    localparam int CNT_W = 6;
    localparam int ROOT_N_W = 62;

    // calibration registers
    logic signed [COORD_W-1:0] cfg_reg [NUM_REGS];

    state_t state_reg;
    job_t   job_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic signed [VEC_W-1:0]   vx_reg, vy_reg;
    logic                      vec_sel_reg, div_sel_reg;
    logic signed [COORD_W-1:0] usx_reg, usy_reg, udx_reg, udy_reg;
    logic signed [COORD_W-1:0] cos_reg, sin_reg;
    logic signed [SHIFT_W-1:0] shx_reg, shy_reg;
    logic                      tr_ready_reg, degen_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [ROOT_N_W-1:0]       sq_n_reg, sq_res_reg, sq_one_reg;
    logic [30:0]               len_reg;
    logic [30:0]               rem_reg, quo_reg;
    logic [61:0]               num_reg;
    logic                      satx_reg;
    logic signed [COORD_W-1:0] mx_reg, my_reg;
    logic [1:0]                status_reg;

    // APB port
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = cfg_reg[paddr[4:2]];

    // difference vectors
    logic signed [VEC_W-1:0] sx, sy, dx, dy;
    logic degen_now;
    assign sx = VEC_W'(cfg_reg[REG_SRC_A_X]) - VEC_W'(cfg_reg[REG_SRC_B_X]);
    assign sy = VEC_W'(cfg_reg[REG_SRC_A_Y]) - VEC_W'(cfg_reg[REG_SRC_B_Y]);
    assign dx = VEC_W'(cfg_reg[REG_DST_A_X]) - VEC_W'(cfg_reg[REG_DST_B_X]);
    assign dy = VEC_W'(cfg_reg[REG_DST_A_Y]) - VEC_W'(cfg_reg[REG_DST_B_Y]);
    assign degen_now = (sx == '0 && sy == '0) || (dx == '0 && dy == '0);

    // normalise step: magnitudes of the current vector
    logic [VEC_W-1:0] mag_x, mag_y, mag_m;
    assign mag_x = vx_reg[VEC_W-1] ? VEC_W'(-vx_reg) : VEC_W'(vx_reg);
    assign mag_y = vy_reg[VEC_W-1] ? VEC_W'(-vy_reg) : VEC_W'(vy_reg);
    assign mag_m = (mag_x > mag_y) ? mag_x : mag_y;

    // shared multiplier operands
    logic signed [VEC_W-1:0] mul_a, mul_b;
    logic                    mac_sub;
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        mac_sub = 1'b0;
        case (job_reg)
            J_SQ:
            begin
                mul_a = cnt_reg[0] ? vy_reg : vx_reg;
                mul_b = mul_a;
            end
            J_COS:
            begin
                mul_a = VEC_W'(cnt_reg[0] ? usy_reg : usx_reg);
                mul_b = VEC_W'(cnt_reg[0] ? udy_reg : udx_reg);
            end
            J_SIN:
            begin
                mul_a = VEC_W'(cnt_reg[0] ? usy_reg : usx_reg);
                mul_b = VEC_W'(cnt_reg[0] ? udx_reg : udy_reg);
                mac_sub = 1'b1;
            end
            J_SHX:
            begin
                mul_a = VEC_W'(cnt_reg[0] ? cfg_reg[REG_SRC_A_Y] : cfg_reg[REG_SRC_A_X]);
                mul_b = VEC_W'(cnt_reg[0] ? sin_reg : cos_reg);
                mac_sub = 1'b1;
            end
            J_SHY:
            begin
                mul_a = VEC_W'(cnt_reg[0] ? cfg_reg[REG_SRC_A_Y] : cfg_reg[REG_SRC_A_X]);
                mul_b = VEC_W'(cnt_reg[0] ? cos_reg : sin_reg);
            end
            J_MAPX:
            begin
                mul_a = VEC_W'(cnt_reg[0] ? py_reg : px_reg);
                mul_b = VEC_W'(cnt_reg[0] ? sin_reg : cos_reg);
                mac_sub = 1'b1;
            end
            J_MAPY:
            begin
                mul_a = VEC_W'(cnt_reg[0] ? py_reg : px_reg);
                mul_b = VEC_W'(cnt_reg[0] ? cos_reg : sin_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    logic signed [PROD_W-1:0] prod;
    assign prod = mul_a * mul_b;

    // rounding of the accumulated sum: add half, floor shift by 30
    logic signed [ACC_W-1:0]   acc_half;
    logic signed [RND_W-1:0]   rnd;
    logic signed [SHIFT_W-1:0] rnd48, map_sum;
    logic signed [SHIFT_W-1:0] cmax, cmin;
    logic signed [COORD_W-1:0] map_sat;
    logic                      map_hit;
    assign acc_half = acc_reg + (ACC_W'(1) <<< (ROT_FRAC - 1));
    assign rnd      = acc_half[ACC_W-1:ROT_FRAC];
    assign rnd48    = SHIFT_W'(rnd);
    assign map_sum  = rnd48 + ((job_reg == J_MAPX) ? shx_reg : shy_reg);
    assign cmax     = SHIFT_W'({1'b0, {(COORD_W-1){1'b1}}});
    assign cmin     = -cmax - SHIFT_W'(1);

    // saturation to the coordinate range
    always_comb
    begin
        map_hit = 1'b0;
        map_sat = map_sum[COORD_W-1:0];
        if (map_sum > cmax)
        begin
            map_hit = 1'b1;
            map_sat = cmax[COORD_W-1:0];
        end
        else if (map_sum < cmin)
        begin
            map_hit = 1'b1;
            map_sat = cmin[COORD_W-1:0];
        end
    end

    // square-root step
    logic [ROOT_N_W-1:0] sq_try;
    logic                sq_ge;
    logic [ROOT_N_W-1:0] sq_res_step;
    assign sq_try = sq_res_reg + sq_one_reg;
    assign sq_ge  = sq_n_reg >= sq_try;
    assign sq_res_step = sq_ge ? ((sq_res_reg >> 1) + sq_one_reg) : (sq_res_reg >> 1);

    // divide: load value and one restoring step
    logic [29:0] div_mag;
    logic [61:0] div_num;
    logic [31:0] div_t;
    logic        div_ge;
    logic [30:0] quo_step;
    logic signed [COORD_W-1:0] u_val;
    logic        div_neg;
    assign div_mag  = div_sel_reg ? mag_y[29:0] : mag_x[29:0];
    assign div_neg  = div_sel_reg ? vy_reg[VEC_W-1] : vx_reg[VEC_W-1];
    assign div_num  = {2'b00, div_mag, 30'd0} + {32'd0, len_reg[30:1]};
    assign div_t    = {rem_reg, num_reg[61]};
    assign div_ge   = div_t >= {1'b0, len_reg};
    assign quo_step = {quo_reg[29:0], div_ge};
    assign u_val    = div_neg ? -COORD_W'(quo_step) : COORD_W'(quo_step);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign mapped_x  = mx_reg;
    assign mapped_y  = my_reg;
    assign status    = status_reg;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                cfg_reg[i] <= '0;
        end
        else if (cfg_wr)
        begin
            cfg_reg[paddr[4:2]] <= pwdata[COORD_W-1:0];
        end
    end

    // sequencer and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            job_reg      <= J_SQ;
            cnt_reg      <= '0;
            cos_reg      <= '0;
            sin_reg      <= '0;
            shx_reg      <= '0;
            shy_reg      <= '0;
            tr_ready_reg <= 1'b0;
            degen_reg    <= 1'b0;
            vec_sel_reg  <= 1'b0;
            div_sel_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
                tr_ready_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        px_reg <= point_x;
                        py_reg <= point_y;
                        cnt_reg <= '0;
                        if (tr_ready_reg)
                        begin
                            if (degen_reg)
                            begin
                                mx_reg     <= point_x;
                                my_reg     <= point_y;
                                status_reg <= STAT_DEGN;
                                state_reg  <= S_OUT;
                            end
                            else
                            begin
                                job_reg   <= J_MAPX;
                                state_reg <= S_MAC;
                            end
                        end
                        else if (degen_now)
                        begin
                            degen_reg    <= 1'b1;
                            tr_ready_reg <= 1'b1;
                            cos_reg      <= COORD_W'(1) <<< ROT_FRAC;
                            sin_reg      <= '0;
                            shx_reg      <= '0;
                            shy_reg      <= '0;
                            mx_reg       <= point_x;
                            my_reg       <= point_y;
                            status_reg   <= STAT_DEGN;
                            state_reg    <= S_OUT;
                        end
                        else
                        begin
                            degen_reg   <= 1'b0;
                            vx_reg      <= sx;
                            vy_reg      <= sy;
                            vec_sel_reg <= 1'b0;
                            state_reg   <= S_NORM;
                        end
                    end
                end
                S_NORM:
                begin
                    // bring the larger magnitude into [2^29, 2^30)
                    if (mag_m >= (VEC_W'(1) << 30))
                    begin
                        vx_reg <= vx_reg >>> 1;
                        vy_reg <= vy_reg >>> 1;
                    end
                    else if (mag_m < (VEC_W'(1) << 29))
                    begin
                        vx_reg <= vx_reg <<< 1;
                        vy_reg <= vy_reg <<< 1;
                    end
                    else
                    begin
                        job_reg   <= J_SQ;
                        cnt_reg   <= '0;
                        state_reg <= S_MAC;
                    end
                end
                S_MAC:
                begin
                    // product registered, then accumulated in the next cycle
                    prod_reg <= prod;
                    cnt_reg  <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                        acc_reg <= ACC_W'(prod_reg);
                    if (cnt_reg == CNT_W'(2))
                    begin
                        acc_reg   <= mac_sub ? acc_reg - ACC_W'(prod_reg)
                                             : acc_reg + ACC_W'(prod_reg);
                        state_reg <= S_POST;
                    end
                end
                S_POST:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_MAC;
                    case (job_reg)
                        J_SQ:
                        begin
                            sq_n_reg   <= acc_reg[ROOT_N_W-1:0];
                            sq_res_reg <= '0;
                            sq_one_reg <= ROOT_N_W'(1) << 60;
                            state_reg  <= S_SQRT;
                        end
                        J_COS:
                        begin
                            cos_reg <= clamp_unit(rnd);
                            job_reg <= J_SIN;
                        end
                        J_SIN:
                        begin
                            sin_reg <= clamp_unit(rnd);
                            job_reg <= J_SHX;
                        end
                        J_SHX:
                        begin
                            shx_reg <= SHIFT_W'(cfg_reg[REG_DST_A_X]) - rnd48;
                            job_reg <= J_SHY;
                        end
                        J_SHY:
                        begin
                            shy_reg      <= SHIFT_W'(cfg_reg[REG_DST_A_Y]) - rnd48;
                            tr_ready_reg <= 1'b1;
                            job_reg      <= J_MAPX;
                        end
                        J_MAPX:
                        begin
                            mx_reg   <= map_sat;
                            satx_reg <= map_hit;
                            job_reg  <= J_MAPY;
                        end
                        J_MAPY:
                        begin
                            my_reg     <= map_sat;
                            status_reg <= (satx_reg | map_hit) ? STAT_SAT : STAT_OK;
                            state_reg  <= S_OUT;
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_SQRT:
                begin
                    // one root bit per cycle
                    if (sq_ge)
                        sq_n_reg <= sq_n_reg - sq_try;
                    sq_res_reg <= sq_res_step;
                    sq_one_reg <= sq_one_reg >> 2;
                    cnt_reg    <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(30))
                    begin
                        len_reg     <= sq_res_step[30:0];
                        div_sel_reg <= 1'b0;
                        cnt_reg     <= '0;
                        state_reg   <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == '0)
                    begin
                        rem_reg <= div_num[61:31];
                        num_reg <= {div_num[30:0], 31'd0};
                        quo_reg <= '0;
                    end
                    else
                    begin
                        // one quotient bit per cycle
                        rem_reg <= div_ge ? 31'(div_t - {1'b0, len_reg}) : div_t[30:0];
                        num_reg <= num_reg << 1;
                        quo_reg <= quo_step;
                        if (cnt_reg == CNT_W'(31))
                        begin
                            cnt_reg <= '0;
                            if (vec_sel_reg)
                            begin
                                if (div_sel_reg)
                                    udy_reg <= u_val;
                                else
                                    udx_reg <= u_val;
                            end
                            else
                            begin
                                if (div_sel_reg)
                                    usy_reg <= u_val;
                                else
                                    usx_reg <= u_val;
                            end
                            div_sel_reg <= 1'b1;
                            if (div_sel_reg)
                            begin
                                if (!vec_sel_reg)
                                begin
                                    vx_reg      <= dx;
                                    vy_reg      <= dy;
                                    vec_sel_reg <= 1'b1;
                                    state_reg   <= S_NORM;
                                end
                                else
                                begin
                                    job_reg   <= J_COS;
                                    state_reg <= S_MAC;
                                end
                            end
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // checks on the sequencer
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input ready while a result is held");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STAT_OK || status == STAT_DEGN || status == STAT_SAT))
        else $error("bad status code");
    a_degen_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STAT_DEGN) |-> degen_reg)
        else $error("degenerate status without degenerate calibration");
    a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NORM) |-> (vx_reg != '0 || vy_reg != '0))
        else $error("normalising a zero vector");

endmodule

`default_nettype wire

// ----- test/tb_two_point_rigid_align_map_unit.sv -----
// Testbench for the two-point rigid alignment map unit: random and directed
// points under several calibrations, checked against a bit-exact predictor.
// Depends on tpra_pkg and two_point_rigid_align_map_unit.
`timescale 1ns / 100ps

typedef logic signed [127:0] wide_t;

typedef struct {
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic [1:0]         st;
} mapped_t;

class align_scoreboard;
    logic [31:0] calib [8];
    longint      cos_q, sin_q, off_x, off_y;
    bit          derived, degenerate;
    mapped_t     pending [$];
    int          errors;

    function new();
        foreach (calib[i]) calib[i] = '0;
        cos_q = 0; sin_q = 0; off_x = 0; off_y = 0;
        derived = 0; degenerate = 0; errors = 0;
    endfunction

    function void write_reg(int idx, logic [31:0] v);
        calib[idx] = v;
        derived    = 0;
    endfunction

    function automatic longint creg(int idx);
        return longint'($signed(calib[idx]));
    endfunction

    // round((a*c1 + b*c2) / 2^30), exact sum then one rounding
    function automatic longint rot_sum(longint a, longint c1, longint b, longint c2);
        wide_t s;
        s = wide_t'(a) * wide_t'(c1) + wide_t'(b) * wide_t'(c2) + (wide_t'(1) <<< 29);
        return longint'(s >>> 30);
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned absval(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    // normalise a difference vector to Q2.30 unit length; 0 if zero length
    function automatic bit to_unit(longint x, longint y, output longint ux,
                                   output longint uy);
        longint unsigned m, ax, ay, len;
        ux = 0; uy = 0;
        if (x == 0 && y == 0) return 0;
        forever begin
            ax = absval(x); ay = absval(y);
            m = ax > ay ? ax : ay;
            if (m < (64'd1 << 30)) break;
            x = x >>> 1; y = y >>> 1;
        end
        while (m < (64'd1 << 29)) begin
            x = x * 2; y = y * 2; m = m * 2;
        end
        ax = absval(x); ay = absval(y);
        len = root_floor(ax * ax + ay * ay);
        ax = ((ax << 30) + len / 2) / len;
        ay = ((ay << 30) + len / 2) / len;
        ux = x < 0 ? -longint'(ax) : longint'(ax);
        uy = y < 0 ? -longint'(ay) : longint'(ay);
        return 1;
    endfunction

    function automatic longint clamp_one(longint v);
        if (v > (64'sd1 <<< 30)) return 64'sd1 <<< 30;
        if (v < -(64'sd1 <<< 30)) return -(64'sd1 <<< 30);
        return v;
    endfunction

    function void derive_transform();
        longint usx, usy, udx, udy;
        bit ok_s, ok_d;
        ok_s = to_unit(creg(tpra_pkg::REG_SRC_A_X) - creg(tpra_pkg::REG_SRC_B_X),
                       creg(tpra_pkg::REG_SRC_A_Y) - creg(tpra_pkg::REG_SRC_B_Y), usx, usy);
        ok_d = to_unit(creg(tpra_pkg::REG_DST_A_X) - creg(tpra_pkg::REG_DST_B_X),
                       creg(tpra_pkg::REG_DST_A_Y) - creg(tpra_pkg::REG_DST_B_Y), udx, udy);
        derived = 1;
        if (!ok_s || !ok_d) begin
            degenerate = 1;
            cos_q = 64'sd1 <<< 30; sin_q = 0; off_x = 0; off_y = 0;
            return;
        end
        degenerate = 0;
        cos_q = clamp_one(rot_sum(usx, udx, usy, udy));
        sin_q = clamp_one(rot_sum(usx, udy, -usy, udx));
        off_x = creg(tpra_pkg::REG_DST_A_X) - rot_sum(creg(tpra_pkg::REG_SRC_A_X), cos_q,
                                                      creg(tpra_pkg::REG_SRC_A_Y), -sin_q);
        off_y = creg(tpra_pkg::REG_DST_A_Y) - rot_sum(creg(tpra_pkg::REG_SRC_A_X), sin_q,
                                                      creg(tpra_pkg::REG_SRC_A_Y), cos_q);
    endfunction

    function automatic logic signed [31:0] clip(longint v, ref bit hit);
        if (v > 64'sd2147483647) begin hit = 1; return 32'sh7fffffff; end
        if (v < -64'sd2147483648) begin hit = 1; return 32'sh80000000; end
        return v[31:0];
    endfunction

    // accepted point: work out its mapped result
    function void note_point(logic signed [31:0] px, logic signed [31:0] py);
        mapped_t r;
        bit hit;
        hit = 0;
        if (!derived) derive_transform();
        if (degenerate) begin
            r.mx = px; r.my = py; r.st = tpra_pkg::STAT_DEGN;
        end else begin
            r.mx = clip(rot_sum(px, cos_q, py, -sin_q) + off_x, hit);
            r.my = clip(rot_sum(px, sin_q, py, cos_q) + off_y, hit);
            r.st = hit ? tpra_pkg::STAT_SAT : tpra_pkg::STAT_OK;
        end
        pending.insert(pending.size(), r);
    endfunction

    function void check_result(logic signed [31:0] mx, logic signed [31:0] my,
                               logic [1:0] st);
        mapped_t e;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h %h %0d", mx, my, st);
            return;
        end
        e = pending.pop_front();
        if (e.mx !== mx || e.my !== my || e.st !== st) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected %h %h %0d, got %h %h %0d",
                         e.mx, e.my, e.st, mx, my, st);
        end
    endfunction
endclass

module tb_two_point_rigid_align_map_unit;
    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [tpra_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 0, in_ready;
    logic signed [31:0] point_x = '0, point_y = '0;
    logic out_valid, out_ready = 0;
    logic signed [31:0] mapped_x, mapped_y;
    logic [1:0] status;

    align_scoreboard sb = new();
    int sender_idle = 0, recv_stall = 0;
    int hold_kick = 0, hold_seen = 0, hold_cnt = 0;
    int quiet = 0;

    two_point_rigid_align_map_unit u_top (.*);

    always #4 clk = ~clk;

    // receiver readiness, with long hold-offs on request
    always @(posedge clk)
    begin
        if (hold_kick != hold_seen) begin
            hold_seen = hold_kick;
            hold_cnt  = 600;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            out_ready <= 1'b0;
        end else
            out_ready <= ($urandom_range(99) >= recv_stall);
    end

    // accepted items and watchdog
    always @(posedge clk)
    begin
        if (in_valid && in_ready) sb.note_point(point_x, point_y);
        if (out_valid && out_ready) sb.check_result(mapped_x, mapped_y, status);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet = 0;
        else if (++quiet > 20000) begin
            $display("FAIL two_point_rigid_align_map_unit");
            $finish;
        end
    end

    task automatic reg_write(int idx, logic [31:0] v);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= tpra_pkg::ADDR_W'(idx * 4); pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        sb.write_reg(idx, v);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic load_calib(logic [31:0] sax, say, sbx, sby, dax, day, dbx, dby);
        // withdraw the last item, wait for all results, then let the block settle
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        reg_write(tpra_pkg::REG_SRC_A_X, sax); reg_write(tpra_pkg::REG_SRC_A_Y, say);
        reg_write(tpra_pkg::REG_SRC_B_X, sbx); reg_write(tpra_pkg::REG_SRC_B_Y, sby);
        reg_write(tpra_pkg::REG_DST_A_X, dax); reg_write(tpra_pkg::REG_DST_A_Y, day);
        reg_write(tpra_pkg::REG_DST_B_X, dbx); reg_write(tpra_pkg::REG_DST_B_Y, dby);
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y);
        if ($urandom_range(99) < sender_idle) begin
            in_valid <= 0;
            @(posedge clk);
            while ($urandom_range(99) < sender_idle) @(posedge clk);
        end
        in_valid <= 1; point_x <= x; point_y <= y;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(9))
            0, 1, 2: return 32'($signed($urandom_range(2097151)) - 1048576);
            3: return 32'h7fffffff;
            4: return 32'h80000000;
            default: return $urandom();
        endcase
    endfunction

    task automatic random_calib();
        logic [31:0] c [8];
        foreach (c[i]) c[i] = rand_coord();
        if ($urandom_range(9) == 0) c[2] = c[0];
        if ($urandom_range(9) == 0) begin c[6] = c[4]; c[7] = c[5]; end
        load_calib(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset calibration is all zero: identity with degenerate status
        send_point(32'h7fffffff, 32'h80000000);
        send_point(32'h0, 32'hffffffff);
        // aligned frames, cos exactly +1
        load_calib(32'h10000, 0, 0, 0, 32'h50000, 32'h20000, 32'h40000, 32'h20000);
        send_point(32'h7fffffff, 32'h7fffffff);
        send_point(32'h80000000, 32'h80000000);
        send_point(32'h12345, 32'hfffe0000);
        // opposite frames, cos exactly -1
        load_calib(32'h10000, 0, 0, 0, 0, 0, 32'h10000, 0);
        send_point(32'h80000000, 32'h0);
        send_point(32'h30000, 32'h40000);
        // quarter turn
        load_calib(0, 0, 32'h10000, 0, 0, 0, 0, 32'h10000);
        send_point(32'h7fffffff, 32'h80000000);
        send_point(32'h10000, 32'h10000);
        // extreme span with the points at the coordinate limits
        load_calib(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                   32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
        send_point(32'h7fffffff, 32'h7fffffff);
        send_point(32'h80000000, 32'h80000000);
        send_point(32'h0, 32'h0);
        // zero-length destination vector
        load_calib(32'h1, 32'h2, 32'h3, 32'h4, 32'h55555, 32'haaaaa, 32'h55555, 32'haaaaa);
        send_point(32'h12345678, 32'h87654321);

        // random phases over the four idling patterns
        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin sender_idle = 0;  recv_stall = 0;  end
                1: begin sender_idle = 63; recv_stall = 0;  end
                2: begin sender_idle = 0;  recv_stall = 63; end
                default: begin sender_idle = 26; recv_stall = 26; end
            endcase
            random_calib();
            for (int k = 0; k < 46; k++) begin
                if (ph == 4 && k == 10) hold_kick++;
                if (ph == 6 && k == 20) begin
                    in_valid <= 0;
                    while (sb.pending.size() != 0) @(posedge clk);
                end
                send_point(rand_coord(), rand_coord());
            end
        end
        in_valid <= 0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS two_point_rigid_align_map_unit");
        else
            $display("FAIL two_point_rigid_align_map_unit");
        $finish;
    end
endmodule
